/* hdl/rcpm_pkg.sv */
// ----------------------------------------------------------------------------
// rcpm_pkg
// Shared types, codes and constants for the RC pulse to motor drive block.
// ----------------------------------------------------------------------------
package rcpm_pkg;

    localparam int unsigned WidthW = 16;
    localparam int unsigned DutyW  = 8;
    localparam int unsigned DirW   = 2;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [DirW-1:0] DIR_STOP    = 2'd0;
    localparam logic [DirW-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DirW-1:0] DIR_REVERSE = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_REVERSE_THRESHOLD = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_FORWARD_THRESHOLD = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_DUTY_MIN          = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_DUTY_MAX          = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_US        = 3'd4;

    localparam logic [WidthW-1:0] RESET_REVERSE_THRESHOLD = 16'd1450;
    localparam logic [WidthW-1:0] RESET_FORWARD_THRESHOLD = 16'd1550;
    localparam logic [DutyW-1:0]  RESET_DUTY_MIN          = 8'd60;
    localparam logic [DutyW-1:0]  RESET_DUTY_MAX          = 8'd100;
    localparam logic [WidthW-1:0] RESET_TIMEOUT_US        = 16'd20000;

    // Product of a 16-bit width offset and an 8-bit duty span
    localparam int unsigned ProdW = WidthW + DutyW;
    // Division by 450: halve, then multiply by ceil(2^31 / 225) and shift
    localparam int unsigned RecipW     = 24;
    localparam int unsigned RecipShift = 31;
    localparam logic [RecipW-1:0] RECIP_225 = 24'd9544372;
    localparam int unsigned RecipProdW = (ProdW - 1) + RecipW;

    typedef struct packed {
        logic [DirW-1:0]   dir;
        logic [WidthW-1:0] width;
        logic [WidthW-1:0] offset;
    } meas_t;

    typedef struct packed {
        logic [DirW-1:0]   dir;
        logic [WidthW-1:0] width;
        logic              neg;
        logic [WidthW-1:0] quot;
    } scaled_t;

endpackage

/* hdl/rcpm_measure.sv */
// ----------------------------------------------------------------------------
// rcpm_measure
// Edge wait and pulse-width counter; classifies each finished pulse.
// ----------------------------------------------------------------------------
module rcpm_measure (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      adv,
    input  logic                      level,
    input  logic [rcpm_pkg::WidthW-1:0] reverse_threshold,
    input  logic [rcpm_pkg::WidthW-1:0] forward_threshold,
    input  logic [rcpm_pkg::WidthW-1:0] timeout_us,
    output rcpm_pkg::meas_t           meas,
    output logic                      meas_valid
);
    import rcpm_pkg::*;

    logic              measuring_reg;
    logic              measuring_next;
    logic [WidthW-1:0] tick_reg;
    logic [WidthW-1:0] tick_next;
    logic [WidthW-1:0] base;
    logic [WidthW:0]   inc;
    logic              limit_hit;
    logic              fin;
    logic [WidthW-1:0] width;
    meas_t             meas_c;
    meas_t             meas_reg;
    logic              meas_valid_reg;

    always_comb
    begin
        base           = (!measuring_reg && level) ? '0 : tick_reg;
        inc            = {1'b0, base} + {{WidthW{1'b0}}, 1'b1};
        limit_hit      = inc >= {1'b0, timeout_us};
        measuring_next = measuring_reg;
        tick_next      = tick_reg;
        fin            = 1'b0;
        width          = '0;
        if (!measuring_reg && !level)
        begin
            if (limit_hit)
            begin
                measuring_next = 1'b1;
                tick_next      = '0;
            end
            else
            begin
                tick_next = inc[WidthW-1:0];
            end
        end
        else if (level)
        begin
            if (limit_hit)
            begin
                fin   = 1'b1;
                width = timeout_us;
            end
            else
            begin
                measuring_next = 1'b1;
                tick_next      = inc[WidthW-1:0];
            end
        end
        else
        begin
            fin   = 1'b1;
            width = (tick_reg < timeout_us) ? tick_reg : timeout_us;
        end
        if (fin)
        begin
            measuring_next = 1'b0;
            tick_next      = '0;
        end
    end

    always_comb
    begin
        meas_c.width = width;
        if (width < reverse_threshold)
        begin
            meas_c.dir    = DIR_REVERSE;
            meas_c.offset = reverse_threshold - width;
        end
        else if (width > forward_threshold)
        begin
            meas_c.dir    = DIR_FORWARD;
            meas_c.offset = width - forward_threshold;
        end
        else
        begin
            meas_c.dir    = DIR_STOP;
            meas_c.offset = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measuring_reg  <= 1'b0;
            tick_reg       <= '0;
            meas_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                measuring_reg <= measuring_next;
                tick_reg      <= tick_next;
            end
            if (adv)
            begin
                meas_valid_reg <= accept && fin;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meas_reg <= meas_c;
        end
    end

    assign meas       = meas_reg;
    assign meas_valid = meas_valid_reg;

endmodule

/* hdl/rcpm_scale.sv */
// ----------------------------------------------------------------------------
// rcpm_scale
// Two-stage duty scaling: offset times duty span, then division by 450.
// ----------------------------------------------------------------------------
module rcpm_scale (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  rcpm_pkg::meas_t            meas,
    input  logic                       meas_valid,
    input  logic [rcpm_pkg::DutyW-1:0] duty_min,
    input  logic [rcpm_pkg::DutyW-1:0] duty_max,
    output rcpm_pkg::scaled_t          scaled,
    output logic                       scaled_valid
);
    import rcpm_pkg::*;

    logic [DutyW:0]      span;
    logic                span_neg;
    logic [DutyW-1:0]    span_mag;
    logic [ProdW-1:0]    prod;
    logic [ProdW-1:0]    prod_reg;
    logic                neg_reg;
    meas_t               meas_reg;
    logic                prod_valid_reg;
    logic [RecipProdW-1:0] recip_prod;
    scaled_t             scaled_c;
    scaled_t             scaled_reg;
    logic                scaled_valid_reg;

    always_comb
    begin
        span     = {1'b0, duty_max} - {1'b0, duty_min};
        span_neg = span[DutyW];
        span_mag = span_neg ? DutyW'(-span) : span[DutyW-1:0];
        prod     = {{DutyW{1'b0}}, meas.offset} * {{WidthW{1'b0}}, span_mag};
    end

    always_comb
    begin
        recip_prod = {{RecipW{1'b0}}, prod_reg[ProdW-1:1]}
                   * {{(ProdW-1){1'b0}}, RECIP_225};
        scaled_c.dir   = meas_reg.dir;
        scaled_c.width = meas_reg.width;
        scaled_c.neg   = neg_reg;
        scaled_c.quot  = recip_prod[RecipShift +: WidthW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg   <= 1'b0;
            scaled_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            prod_valid_reg   <= meas_valid;
            scaled_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= prod;
            neg_reg    <= span_neg;
            meas_reg   <= meas;
            scaled_reg <= scaled_c;
        end
    end

    assign scaled       = scaled_reg;
    assign scaled_valid = scaled_valid_reg;

endmodule

/* hdl/rcpm_output.sv */
// ----------------------------------------------------------------------------
// rcpm_output
// Offset and clamp of the scaled duty, held duty over stop, result register.
// ----------------------------------------------------------------------------
module rcpm_output (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  rcpm_pkg::scaled_t           scaled,
    input  logic                        scaled_valid,
    input  logic [rcpm_pkg::DutyW-1:0]  duty_min,
    input  logic [rcpm_pkg::DutyW-1:0]  duty_max,
    output logic                        out_valid,
    output logic [rcpm_pkg::DirW-1:0]   direction,
    output logic [rcpm_pkg::DutyW-1:0]  duty,
    output logic [rcpm_pkg::WidthW-1:0] pulse_us
);
    import rcpm_pkg::*;

    localparam int unsigned SumW = WidthW + 2;

    logic signed [SumW-1:0] quot_s;
    logic signed [SumW-1:0] level_s;
    logic [DutyW-1:0]       clamped;
    logic [DutyW-1:0]       duty_next;
    logic [DutyW-1:0]       held_duty_reg;
    logic                   out_valid_reg;
    logic [DirW-1:0]        direction_reg;
    logic [DutyW-1:0]       duty_reg;
    logic [WidthW-1:0]      pulse_us_reg;

    always_comb
    begin
        quot_s  = $signed({2'b00, scaled.quot});
        if (scaled.neg)
        begin
            quot_s = -quot_s;
        end
        level_s = quot_s + $signed({{(SumW-DutyW){1'b0}}, duty_min});
        if (level_s < 0)
        begin
            clamped = '0;
        end
        else if (level_s > $signed({{(SumW-DutyW){1'b0}}, duty_max}))
        begin
            clamped = duty_max;
        end
        else
        begin
            clamped = level_s[DutyW-1:0];
        end
        duty_next = (scaled.dir == DIR_STOP) ? held_duty_reg : clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_duty_reg <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= scaled_valid;
            if (scaled_valid)
            begin
                held_duty_reg <= duty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            direction_reg <= scaled.dir;
            duty_reg      <= duty_next;
            pulse_us_reg  <= scaled.width;
        end
    end

    assign out_valid = out_valid_reg;
    assign direction = direction_reg;
    assign duty      = duty_reg;
    assign pulse_us  = pulse_us_reg;

endmodule

/* hdl/rc_pulse_to_motor_drive.sv */
// Result path: the tick that ends the pulse passes the measure, product,
// quotient and output registers. Throughput: one tick per cycle; the four-stage
// pipeline advances together and holds only while a result waits at the output.
// Reset: clears the pipeline, the edge/measure state and the held duty, and
// loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// rc_pulse_to_motor_drive
// RC receiver pulse width to H-bridge direction and PWM duty.
// ----------------------------------------------------------------------------
module rc_pulse_to_motor_drive (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rcpm_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rcpm_pkg::CfgDataW-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          receiver_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rcpm_pkg::DirW-1:0]     direction,
    output logic [rcpm_pkg::DutyW-1:0]    duty,
    output logic [rcpm_pkg::WidthW-1:0]   pulse_us
);
    import rcpm_pkg::*;

    logic [WidthW-1:0] reverse_threshold_reg;
    logic [WidthW-1:0] forward_threshold_reg;
    logic [DutyW-1:0]  duty_min_reg;
    logic [DutyW-1:0]  duty_max_reg;
    logic [WidthW-1:0] timeout_us_reg;
    logic              adv;
    logic              accept;
    meas_t             meas;
    logic              meas_valid;
    scaled_t           scaled;
    logic              scaled_valid;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign accept    = in_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_threshold_reg <= RESET_REVERSE_THRESHOLD;
            forward_threshold_reg <= RESET_FORWARD_THRESHOLD;
            duty_min_reg          <= RESET_DUTY_MIN;
            duty_max_reg          <= RESET_DUTY_MAX;
            timeout_us_reg        <= RESET_TIMEOUT_US;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REVERSE_THRESHOLD: reverse_threshold_reg <= cfg_data;
                CFG_FORWARD_THRESHOLD: forward_threshold_reg <= cfg_data;
                CFG_DUTY_MIN:          duty_min_reg          <= cfg_data[DutyW-1:0];
                CFG_DUTY_MAX:          duty_max_reg          <= cfg_data[DutyW-1:0];
                CFG_TIMEOUT_US:        timeout_us_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    rcpm_measure u_measure (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .adv               (adv),
        .level             (receiver_level),
        .reverse_threshold (reverse_threshold_reg),
        .forward_threshold (forward_threshold_reg),
        .timeout_us        (timeout_us_reg),
        .meas              (meas),
        .meas_valid        (meas_valid)
    );

    rcpm_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .meas         (meas),
        .meas_valid   (meas_valid),
        .duty_min     (duty_min_reg),
        .duty_max     (duty_max_reg),
        .scaled       (scaled),
        .scaled_valid (scaled_valid)
    );

    rcpm_output u_output (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .scaled       (scaled),
        .scaled_valid (scaled_valid),
        .duty_min     (duty_min_reg),
        .duty_max     (duty_max_reg),
        .out_valid    (out_valid),
        .direction    (direction),
        .duty         (duty),
        .pulse_us     (pulse_us)
    );

    a_ready_low_only_on_held_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid
    ) else $error("input stalled without a pending result");

    a_drive_duty_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && direction != DIR_STOP |-> duty <= duty_max_reg
    ) else $error("drive duty above full scale");

    a_pulse_capped: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> pulse_us <= timeout_us_reg
    ) else $error("pulse width above timeout");

    a_stop_holds_duty: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid && direction == DIR_STOP
        |-> duty == $past(duty)
    ) else $error("stop result changed the held duty");

endmodule

/* tb/rcpm_drive_checker.sv */
// ----------------------------------------------------------------------------
// rcpm_drive_checker
// Watches the register, tick and drive channels of the RC pulse to motor
// drive block. Predicts the drive result of every pulse that an accepted tick
// ends and compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rcpm_drive_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [rcpm_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rcpm_pkg::CfgDataW-1:0] cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          receiver_level,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [rcpm_pkg::DirW-1:0]     direction,
    input  logic [rcpm_pkg::DutyW-1:0]    duty,
    input  logic [rcpm_pkg::WidthW-1:0]   pulse_us,
    output int unsigned                   fail_count,
    output int unsigned                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rcpm_pkg::*;

    localparam int SpanUs = 450;

    typedef struct packed {
        logic [DirW-1:0]   dir;
        logic [DutyW-1:0]  duty;
        logic [WidthW-1:0] width;
    } drive_t;

    logic [WidthW-1:0] rev_thr;
    logic [WidthW-1:0] fwd_thr;
    logic [DutyW-1:0]  dmin;
    logic [DutyW-1:0]  dmax;
    logic [WidthW-1:0] tmo;

    logic              measuring;
    logic [WidthW-1:0] tick_count;
    logic [DutyW-1:0]  held_duty;

    drive_t      drive_expected[$];
    drive_t      seen;
    drive_t      want;
    int unsigned mismatches;

    function automatic logic [DutyW-1:0] scaled_duty(input logic [WidthW-1:0] offset);
        longint span;
        longint level;
        span  = longint'(dmax) - longint'(dmin);
        level = (longint'(offset) * span) / SpanUs + longint'(dmin);
        if (level < 0)
            level = 0;
        if (level > longint'(dmax))
            level = longint'(dmax);
        return level[DutyW-1:0];
    endfunction

    task automatic close_pulse(input logic [WidthW-1:0] measured);
        drive_t            res;
        logic [WidthW-1:0] w;
        w = (measured > tmo) ? tmo : measured;
        if (w < rev_thr)
        begin
            res.dir   = DIR_REVERSE;
            held_duty = scaled_duty(rev_thr - w);
        end
        else if (w > fwd_thr)
        begin
            res.dir   = DIR_FORWARD;
            held_duty = scaled_duty(w - fwd_thr);
        end
        else
        begin
            res.dir = DIR_STOP;
        end
        res.duty  = held_duty;
        res.width = w;
        drive_expected.push_back(res);
        measuring  = 1'b0;
        tick_count = '0;
    endtask

    task automatic advance_tick(input logic level);
        logic [WidthW:0] bumped;
        if (!measuring && !level)
        begin
            bumped = {1'b0, tick_count} + {{WidthW{1'b0}}, 1'b1};
            if (bumped >= {1'b0, tmo})
            begin
                measuring  = 1'b1;
                tick_count = '0;
            end
            else
            begin
                tick_count = bumped[WidthW-1:0];
            end
        end
        else
        begin
            if (!measuring)
            begin
                measuring  = 1'b1;
                tick_count = '0;
            end
            if (level)
            begin
                bumped = {1'b0, tick_count} + {{WidthW{1'b0}}, 1'b1};
                if (bumped >= {1'b0, tmo})
                    close_pulse(tmo);
                else
                    tick_count = bumped[WidthW-1:0];
            end
            else
            begin
                close_pulse(tick_count);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_thr    = RESET_REVERSE_THRESHOLD;
            fwd_thr    = RESET_FORWARD_THRESHOLD;
            dmin       = RESET_DUTY_MIN;
            dmax       = RESET_DUTY_MAX;
            tmo        = RESET_TIMEOUT_US;
            measuring  = 1'b0;
            tick_count = '0;
            held_duty  = '0;
            mismatches = 0;
            drive_expected.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_REVERSE_THRESHOLD: rev_thr = cfg_data;
                    CFG_FORWARD_THRESHOLD: fwd_thr = cfg_data;
                    CFG_DUTY_MIN:          dmin    = cfg_data[DutyW-1:0];
                    CFG_DUTY_MAX:          dmax    = cfg_data[DutyW-1:0];
                    CFG_TIMEOUT_US:        tmo     = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                seen.dir   = direction;
                seen.duty  = duty;
                seen.width = pulse_us;
                if (drive_expected.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected drive transfer: dir=%0d duty=%0d pulse=%0d",
                                 $time, seen.dir, seen.duty, seen.width);
                    mismatches++;
                end
                else
                begin
                    want = drive_expected.pop_front();
                    if (seen.dir !== want.dir || seen.duty !== want.duty ||
                        seen.width !== want.width)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("[%0t] mismatch: expected dir=%0d duty=%0d pulse=%0d",
                                     $time, want.dir, want.duty, want.width);
                            $display("[%0t]   got dir=%0d duty=%0d pulse=%0d",
                                     $time, seen.dir, seen.duty, seen.width);
                        end
                        mismatches++;
                    end
                end
            end

            if (in_valid && in_ready)
                advance_tick(receiver_level);

            fail_count <= mismatches;
            pending    <= drive_expected.size();
        end
    end

endmodule

/* tb/tb_rc_pulse_to_motor_drive.sv */
// ----------------------------------------------------------------------------
// tb_rc_pulse_to_motor_drive
// Drives receiver ticks and register writes into the RC pulse to motor drive
// block: a short directed run over the dead band, both timeouts, a zero
// timeout, duty clamping and unused register indexes, then random phases of
// pulse trains under changing settings, with idle bursts on both channels and
// one long output hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_rc_pulse_to_motor_drive;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpm_pkg::*;

    localparam int unsigned TickItems    = 2000;
    localparam int unsigned HoldCycles   = 300;
    localparam int unsigned SettleCycles = 8;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_FIRST = CFG_TIMEOUT_US + 1'b1;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_LAST  = '1;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic                receiver_level;
    logic                out_valid;
    logic                out_ready;
    logic [DirW-1:0]     direction;
    logic [DutyW-1:0]    duty;
    logic [WidthW-1:0]   pulse_us;
    int unsigned         fail_count;
    int unsigned         pending;

    logic              quiet;
    logic              hold_off;
    bit                sender_gaps;
    int unsigned       ticks_sent;
    logic [WidthW-1:0] rev_thr;
    logic [WidthW-1:0] fwd_thr;
    logic [WidthW-1:0] tmo;

    rc_pulse_to_motor_drive dut (.*);

    rcpm_drive_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("[rc_pulse_to_motor_drive] ERROR");
        $finish;
    end

    task automatic send_tick(input logic level);
        if (!quiet && sender_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        receiver_level <= level;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic send_run(input logic level, input int count);
        repeat (count) send_tick(level);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (index)
            CFG_REVERSE_THRESHOLD: rev_thr = data;
            CFG_FORWARD_THRESHOLD: fwd_thr = data;
            CFG_TIMEOUT_US:        tmo     = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [WidthW-1:0] r, input logic [WidthW-1:0] f,
                                  input logic [DutyW-1:0] lo, input logic [DutyW-1:0] hi,
                                  input logic [WidthW-1:0] t);
        set_reg(CFG_REVERSE_THRESHOLD, r);
        set_reg(CFG_FORWARD_THRESHOLD, f);
        set_reg(CFG_DUTY_MIN, {8'($urandom), lo});
        set_reg(CFG_DUTY_MAX, {8'($urandom), hi});
        set_reg(CFG_TIMEOUT_US, t);
    endtask

    task automatic pick_settings(input bit write_all);
        logic [WidthW-1:0] r;
        logic [WidthW-1:0] f;
        logic [WidthW-1:0] t;
        logic [DutyW-1:0]  lo;
        logic [DutyW-1:0]  hi;
        case ($urandom_range(0, 9))
            0:       r = '0;
            1:       r = '1;
            default: r = 16'($urandom_range(0, 60));
        endcase
        case ($urandom_range(0, 9))
            0:       f = '0;
            1:       f = '1;
            2:       f = 16'($urandom_range(0, r));
            default: f = (r > 16'd65495) ? '1 : 16'(r + $urandom_range(0, 40));
        endcase
        case ($urandom_range(0, 9))
            0:       lo = '0;
            1:       lo = '1;
            default: lo = 8'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       hi = 8'd1;
            1:       hi = '1;
            default: hi = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 11))
            0:       t = '0;
            1:       t = 16'd1;
            2:       t = '1;
            3:       t = 16'($urandom_range(700, 2000));
            default: t = 16'($urandom_range(1, 120));
        endcase
        if (write_all || $urandom_range(0, 2) != 0)
            set_reg(CFG_REVERSE_THRESHOLD, r);
        if (write_all || $urandom_range(0, 2) != 0)
            set_reg(CFG_FORWARD_THRESHOLD, f);
        if (write_all || $urandom_range(0, 2) != 0)
            set_reg(CFG_DUTY_MIN, {8'($urandom), lo});
        if (write_all || $urandom_range(0, 2) != 0)
            set_reg(CFG_DUTY_MAX, {8'($urandom), hi});
        if (write_all || $urandom_range(0, 2) != 0)
            set_reg(CFG_TIMEOUT_US, t);
        if ($urandom_range(0, 3) == 0)
            set_reg(CfgIdxW'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), 16'($urandom));
    endtask

    task automatic send_pulse();
        int hi_len;
        int lo_len;
        case ($urandom_range(0, 9))
            0:       hi_len = int'(rev_thr);
            1:       hi_len = int'(rev_thr) - 1;
            2:       hi_len = int'(fwd_thr);
            3:       hi_len = int'(fwd_thr) + 1;
            4:       hi_len = int'(tmo);
            5:       hi_len = int'(tmo) - 1;
            default: hi_len = $urandom_range(1, int'(fwd_thr) + 20);
        endcase
        if (hi_len < 0 || hi_len > 200)
            hi_len = $urandom_range(1, 200);
        if (tmo >= 16'd700 && $urandom_range(0, 5) == 0)
            hi_len = $urandom_range(460, 700);
        if (tmo <= 16'd40 && $urandom_range(0, 4) == 0)
            lo_len = int'(tmo) + $urandom_range(0, 3);
        else
            lo_len = $urandom_range(1, 12);
        send_run(1'b0, lo_len);
        send_run(1'b1, hi_len);
    endtask

    // receiver side: random stalls, one long hold-off, none once quiet
    initial
    begin
        bit held_done;
        held_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_off && !held_done)
            begin
                held_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned base;
        int unsigned phase;
        int unsigned waited;

        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        receiver_level <= 1'b0;
        quiet          <= 1'b0;
        hold_off       <= 1'b0;
        sender_gaps = 1'b1;
        ticks_sent  = 0;
        rev_thr     = RESET_REVERSE_THRESHOLD;
        fwd_thr     = RESET_FORWARD_THRESHOLD;
        tmo         = RESET_TIMEOUT_US;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dead band first, so the reset duty shows, then both timeouts
        apply_settings(16'd2, 16'd3, 8'd7, 8'd255, 16'd4);
        send_run(1'b1, 3);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 4);
        send_run(1'b0, 5);

        // lower the limit in the middle of a pulse
        wait_idle();
        set_reg(CFG_TIMEOUT_US, 16'd20);
        send_run(1'b1, 6);
        wait_idle();
        set_reg(CFG_TIMEOUT_US, 16'd3);
        send_run(1'b0, 1);

        // zero timeout, negative duty clamped to zero
        wait_idle();
        apply_settings('1, '1, 8'd10, 8'd1, '0);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 2);

        // saturate at full scale
        wait_idle();
        set_reg(CFG_DUTY_MIN, {8'($urandom), 8'd0});
        set_reg(CFG_DUTY_MAX, {8'($urandom), 8'd255});
        send_run(1'b0, 1);
        send_run(1'b1, 1);

        // minimum above maximum, zero thresholds
        wait_idle();
        apply_settings('0, '0, 8'd200, 8'd50, 16'd1);
        send_run(1'b1, 1);
        send_run(1'b0, 2);

        wait_idle();
        set_reg(CFG_SPARE_FIRST, 16'($urandom));
        set_reg(CFG_SPARE_LAST, 16'($urandom));

        base  = ticks_sent;
        phase = 0;
        while (ticks_sent - base < TickItems)
        begin
            wait_idle();
            pick_settings(phase == 0);
            if (!hold_off && ((tmo != 0 && tmo <= 16'd120) || phase >= 4))
                hold_off <= 1'b1;
            if (ticks_sent - base >= TickItems * 4 / 5)
                quiet <= 1'b1;
            sender_gaps = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8))
            begin
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
                else
                    send_pulse();
            end
            // leave the pulse open half the time
            if ($urandom_range(0, 1) == 0)
                send_tick(1'b0);
            phase++;
        end

        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending != 0 && waited < 20000);
        repeat (2 * SettleCycles) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("[rc_pulse_to_motor_drive] OK");
        else
            $display("[rc_pulse_to_motor_drive] ERROR");
        $finish;
    end

endmodule
